>>> rtl/fpda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpda_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_A_FMT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B_FMT = 2'd1;

    // fp32 constants
    localparam logic [31:0] QNAN_BITS = 32'h7fc0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hff;
    localparam logic [7:0]  FP32_BIAS = 8'd127;

    // Exact FP8 x FP8 product in fp32-like form
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        sign;
        logic [7:0]  exp;   // biased fp32 exponent, 0 when zero
        logic [23:0] sig;   // normalized significand, hidden bit at [23]
    } prod_t;

endpackage

`default_nettype wire

>>> rtl/fpda_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module fpda_mul (
    input  wire logic [7:0]     a_code,
    input  wire logic [7:0]     b_code,
    input  wire logic           a_alt_fmt,
    input  wire logic           b_alt_fmt,
    output fpda_pkg::prod_t     prod
);
    import fpda_pkg::*;

    typedef struct packed {
        logic              sign;
        logic              nan;
        logic              inf;
        logic [3:0]        sig;   // value = sig * 2^exp
        logic signed [6:0] exp;
    } fp8_dec_t;

    function automatic fp8_dec_t decode(input logic [7:0] code, input logic e5);
        fp8_dec_t   d;
        logic [4:0] e5f;
        logic [3:0] e4f;
        logic [4:0] e_eff;
        d.sign = code[7];
        if (e5)
        begin
            e5f   = code[6:2];
            e_eff = (e5f == 5'd0) ? 5'd1 : e5f;
            d.nan = (e5f == 5'h1f) && (code[1:0] != 2'd0);
            d.inf = (e5f == 5'h1f) && (code[1:0] == 2'd0);
            d.sig = {(e5f != 5'd0), code[1:0], 1'b0};
            d.exp = $signed({2'b00, e_eff}) - 7'sd18;
        end
        else
        begin
            e4f   = code[6:3];
            e_eff = {1'b0, ((e4f == 4'd0) ? 4'd1 : e4f)};
            d.nan = (e4f == 4'hf) && (code[2:0] == 3'h7);
            d.inf = 1'b0;
            d.sig = {(e4f != 4'd0), code[2:0]};
            d.exp = $signed({2'b00, e_eff}) - 7'sd10;
        end
        return d;
    endfunction

    fp8_dec_t          da;
    fp8_dec_t          db;
    logic [7:0]        p;
    logic [2:0]        msb;
    logic signed [8:0] pexp;
    logic              za;
    logic              zb;

    // Decode both operands and form the exact product
    always_comb
    begin
        da  = decode(a_code, a_alt_fmt);
        db  = decode(b_code, b_alt_fmt);
        za  = (da.sig == 4'd0);
        zb  = (db.sig == 4'd0);
        p   = da.sig * db.sig;
        msb = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (p[i])
            begin
                msb = 3'(i);
            end
        end
        pexp = {{2{da.exp[6]}}, da.exp} + {{2{db.exp[6]}}, db.exp}
             + {6'd0, msb} + {1'b0, FP32_BIAS};

        prod.sign = da.sign ^ db.sign;
        prod.nan  = da.nan || db.nan || (da.inf && zb) || (db.inf && za);
        prod.inf  = da.inf || db.inf;
        if (p == 8'd0)
        begin
            prod.exp = 8'd0;
            prod.sig = 24'd0;
        end
        else
        begin
            prod.exp = pexp[7:0];
            prod.sig = {p, 16'd0} << (3'd7 - msb);
        end
    end

endmodule

`default_nettype wire

>>> rtl/fpda_add.sv
`timescale 1ns / 1ps
`default_nettype none

module fpda_add (
    input  wire logic [31:0]    acc,
    input  wire fpda_pkg::prod_t prod,
    output logic [31:0]         sum
);
    import fpda_pkg::*;

    logic              acc_nan;
    logic              acc_inf;
    logic [7:0]        acc_exp;
    logic [23:0]       acc_sig;
    logic              acc_big;
    logic [7:0]        big_exp;
    logic [7:0]        sml_exp;
    logic [23:0]       big_sig;
    logic [23:0]       sml_sig;
    logic              big_sign;
    logic              eff_sub;
    logic [7:0]        shift_amt;
    logic [26:0]       sml_ext;
    logic [26:0]       shifted;
    logic              lost;
    logic [27:0]       raw;
    logic [26:0]       norm;
    logic [4:0]        lz;
    logic signed [9:0] ex;
    logic signed [9:0] ex_r;
    logic              up;
    logic [24:0]       mant;

    always_comb
    begin
        // Unpack the accumulator
        acc_nan = (acc[30:23] == EXP_MAX) && (acc[22:0] != 23'd0);
        acc_inf = (acc[30:23] == EXP_MAX) && (acc[22:0] == 23'd0);
        acc_exp = (acc[30:23] == 8'd0) ? 8'd1 : acc[30:23];
        acc_sig = {(acc[30:23] != 8'd0), acc[22:0]};

        // Order the operands by magnitude
        acc_big  = {acc_exp, acc_sig} >= {prod.exp, prod.sig};
        big_exp  = acc_big ? acc_exp : prod.exp;
        big_sig  = acc_big ? acc_sig : prod.sig;
        big_sign = acc_big ? acc[31] : prod.sign;
        sml_exp  = acc_big ? prod.exp : acc_exp;
        sml_sig  = acc_big ? prod.sig : acc_sig;
        eff_sub  = acc[31] ^ prod.sign;

        // Align the smaller operand with guard, round and sticky
        shift_amt = big_exp - sml_exp;
        sml_ext   = {sml_sig, 3'd0};
        if (shift_amt >= 8'd27)
        begin
            shifted = 27'd0;
            lost    = |sml_sig;
        end
        else
        begin
            shifted = sml_ext >> shift_amt[4:0];
            lost    = |(sml_ext & ~({27{1'b1}} << shift_amt[4:0]));
        end
        shifted[0] = shifted[0] | lost;

        raw = eff_sub ? ({1'b0, big_sig, 3'd0} - {1'b0, shifted})
                      : ({1'b0, big_sig, 3'd0} + {1'b0, shifted});

        // Normalize
        lz = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (raw[i])
            begin
                lz = 5'(26 - i);
            end
        end
        if (raw[27])
        begin
            norm = {raw[27:2], raw[1] | raw[0]};
            ex   = $signed({2'b00, big_exp}) + 10'sd1;
        end
        else
        begin
            norm = raw[26:0] << lz;
            ex   = $signed({2'b00, big_exp}) - $signed({5'd0, lz});
        end

        // Round to nearest even
        up   = norm[2] && (norm[1] || norm[0] || norm[3]);
        mant = {1'b0, norm[26:3]} + {24'd0, up};
        ex_r = ex + $signed({9'd0, mant[24]});

        // Select special results
        if (acc_nan || prod.nan || (acc_inf && prod.inf && eff_sub))
        begin
            sum = QNAN_BITS;
        end
        else if (acc_inf)
        begin
            sum = acc;
        end
        else if (prod.inf)
        begin
            sum = {prod.sign, EXP_MAX, 23'd0};
        end
        else if (raw == 28'd0)
        begin
            sum = {acc[31] && prod.sign, 31'd0};
        end
        else if (ex_r >= $signed({2'b00, EXP_MAX}))
        begin
            sum = {big_sign, EXP_MAX, 23'd0};
        end
        else
        begin
            sum = {big_sign, ex_r[7:0], mant[22:0]};
        end
    end

endmodule

`default_nettype wire

>>> rtl/fp8_dot_product_accumulate.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------
// in       | in_valid / in_ready     | a_code, b_code, last_term
// out      | out_valid / out_ready   | sum_bits
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One pair per cycle while no waiting result holds the pipe; a sum shows on sum_bits
// once its last pair has passed the input register, the product register and the
// accumulator add into the result register. The fp32 add closes a loop on acc_reg.
// Reset clears the accumulator to +0 and both formats to E4M3.
// A waiting result stalls only when the next last pair reaches the adder.

module fp8_dot_product_accumulate (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     a_code,
    input  wire logic [7:0]                     b_code,
    input  wire logic                           last_term,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [31:0]                         sum_bits,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fpda_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_data
);
    import fpda_pkg::*;

    logic        a_fmt_reg;
    logic        b_fmt_reg;
    logic        s1_valid_reg;
    logic [7:0]  a_code_reg;
    logic [7:0]  b_code_reg;
    logic        s1_last_reg;
    logic        s2_valid_reg;
    logic        s2_last_reg;
    prod_t       prod_reg;
    prod_t       prod_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        out_valid_reg;
    logic [31:0] sum_reg;
    logic        s2_fire;
    logic        s2_free;
    logic        s1_move;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sum_bits  = sum_reg;

    // Pipeline flow control
    assign s2_fire  = s2_valid_reg && (!s2_last_reg || !out_valid_reg || out_ready);
    assign s2_free  = !s2_valid_reg || s2_fire;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    fpda_mul u_mul (
        .a_code    (a_code_reg),
        .b_code    (b_code_reg),
        .a_alt_fmt (a_fmt_reg),
        .b_alt_fmt (b_fmt_reg),
        .prod      (prod_next)
    );

    fpda_add u_add (
        .acc  (acc_reg),
        .prod (prod_reg),
        .sum  (acc_next)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_fmt_reg <= 1'b0;
            b_fmt_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_A_FMT: a_fmt_reg <= cfg_data;
                REG_B_FMT: b_fmt_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Advance the pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 32'd0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_move;
            end
            if (s2_fire)
            begin
                acc_reg <= s2_last_reg ? 32'd0 : acc_next;
            end
            if (s2_fire && s2_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_code_reg  <= a_code;
            b_code_reg  <= b_code;
            s1_last_reg <= last_term;
        end
        if (s1_move)
        begin
            prod_reg    <= prod_next;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_fire && s2_last_reg)
        begin
            sum_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fpda_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fpda_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [7:0]                     a_code,
    input  wire logic [7:0]                     b_code,
    input  wire logic                           last_term,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [31:0]                    sum_bits,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [fpda_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_data
);
    import fpda_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_bits))
        else $error("result beat changed while stalled");

    // Hold a stalled input beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable({a_code, b_code, last_term}))
        else $error("input beat changed while stalled");

    // Emit only the canonical NaN
    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sum_bits[30:23] == EXP_MAX && sum_bits[22:0] != 23'd0
        |-> sum_bits == QNAN_BITS)
        else $error("non-canonical NaN on output");

    // Never stall input while no result is waiting
    a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Take every configuration beat with a known payload
    a_cfg_take: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
        else $error("configuration beat refused or unknown");

endmodule

bind fp8_dot_product_accumulate fpda_checker u_fpda_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fpda_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int ITEMS_PHASE = 320;

    // fp32 helpers used by the dot-product predictor
    function automatic logic fp32_is_nan(logic [31:0] x);
        return (x[30:23] == 8'hff) && (x[22:0] != 0);
    endfunction

    function automatic logic fp32_is_inf(logic [31:0] x);
        return (x[30:23] == 8'hff) && (x[22:0] == 0);
    endfunction

    // Exact FP8 to fp32 conversion
    function automatic logic [31:0] fp8_to_fp32(logic [7:0] code, logic is_e5m2);
        logic [4:0] ex;
        logic [2:0] man;
        int         k;
        int         sub_exp;
        if (is_e5m2) begin
            ex = code[6:2];
            man = {1'b0, code[1:0]};
            sub_exp = 127 - 16;
            if (ex == 5'd31)
                return (man != 0) ? QNAN_BITS : {code[7], 8'hff, 23'd0};
        end
        else begin
            ex = {1'b0, code[6:3]};
            man = code[2:0];
            sub_exp = 127 - 9;
            if (ex == 5'd15 && man == 3'd7)
                return QNAN_BITS;
        end
        if (ex == 0) begin
            if (man == 0)
                return {code[7], 31'd0};
            k = 0;
            for (int i = 0; i < 3; i++)
                if (man[i])
                    k = i;
            return {code[7], 8'(sub_exp + k), 23'((32'(man) << (23 - k)) & 32'h7fffff)};
        end
        if (is_e5m2)
            return {code[7], 8'(ex + 112), man[1:0], 21'd0};
        return {code[7], 8'(ex + 120), man, 20'd0};
    endfunction

    // Exact product of two decoded operands (always normal, zero, inf or NaN)
    function automatic logic [31:0] fp32_mul_exact(logic [31:0] x, logic [31:0] y);
        logic        s;
        logic [47:0] p;
        int          e;
        s = x[31] ^ y[31];
        if (fp32_is_nan(x) || fp32_is_nan(y))
            return QNAN_BITS;
        if (fp32_is_inf(x) || fp32_is_inf(y)) begin
            if (x[30:0] == 0 || y[30:0] == 0)
                return QNAN_BITS;
            return {s, 8'hff, 23'd0};
        end
        if (x[30:0] == 0 || y[30:0] == 0)
            return {s, 31'd0};
        p = {1'b1, x[22:0]} * {1'b1, y[22:0]};
        e = int'(x[30:23]) + int'(y[30:23]) - 127;
        if (p[47])
            return {s, 8'(e + 1), p[46:24]};
        return {s, 8'(e), p[45:23]};
    endfunction

    // fp32 add, round to nearest even
    function automatic logic [31:0] fp32_add_rne(logic [31:0] x, logic [31:0] y);
        logic [31:0] big;
        logic [31:0] sml;
        logic [65:0] ma;
        logic [65:0] ms;
        logic [65:0] r;
        logic [24:0] rs;
        logic        sub;
        logic        g;
        logic        st;
        int          eb;
        int          es;
        int          d;
        int          p;
        int          e;
        if (fp32_is_nan(x) || fp32_is_nan(y))
            return QNAN_BITS;
        if (fp32_is_inf(x) && fp32_is_inf(y))
            return (x[31] != y[31]) ? QNAN_BITS : x;
        if (fp32_is_inf(x))
            return x;
        if (fp32_is_inf(y))
            return y;
        if (x[30:0] >= y[30:0]) begin
            big = x;
            sml = y;
        end
        else begin
            big = y;
            sml = x;
        end
        ma = 66'({big[30:23] != 0, big[22:0]}) << 40;
        ms = 66'({sml[30:23] != 0, sml[22:0]}) << 40;
        eb = (big[30:23] == 0) ? 1 : int'(big[30:23]);
        es = (sml[30:23] == 0) ? 1 : int'(sml[30:23]);
        d = eb - es;
        if (d >= 66)
            ms = 66'(ms != 0);
        else if (d > 0)
            ms = (ms >> d) | 66'((ms & ((66'd1 << d) - 1)) != 0);
        sub = big[31] ^ sml[31];
        r = sub ? ma - ms : ma + ms;
        if (r == 0)
            return sub ? 32'd0 : {big[31], 31'd0};
        p = 0;
        for (int i = 0; i < 66; i++)
            if (r[i])
                p = i;
        e = eb;
        if (p == 64) begin
            r = (r >> 1) | 66'(r[0]);
            e = e + 1;
        end
        else if (p < 63) begin
            r = r << (63 - p);
            e = e - (63 - p);
        end
        // Denormalize when below the normal range
        if (e < 1) begin
            d = 1 - e;
            if (d >= 66)
                r = 66'(r != 0);
            else
                r = (r >> d) | 66'((r & ((66'd1 << d) - 1)) != 0);
            e = 0;
        end
        g = r[39];
        st = |r[38:0];
        rs = 25'(r[63:40]) + 25'(g && (st || r[40]));
        if (rs[24]) begin
            rs = rs >> 1;
            e = e + 1;
        end
        if (e == 0 && rs[23])
            e = 1;
        if (e >= 255)
            return {big[31], 8'hff, 23'd0};
        return {big[31], 8'(e), rs[22:0]};
    endfunction

    // Dot-product predictor and expected-sum store
    class dot_sum_checker;
        logic        a_fmt;
        logic        b_fmt;
        logic [31:0] running_sum;
        logic [31:0] pending_sums[$];
        int          sums_checked;
        int          mismatches;

        function void clear();
            a_fmt = 1'b0;
            b_fmt = 1'b0;
            running_sum = 32'd0;
            pending_sums.delete();
            sums_checked = 0;
            mismatches = 0;
        endfunction

        function void note_pair(logic [7:0] a, logic [7:0] b, logic last);
            logic [31:0] prod;
            prod = fp32_mul_exact(fp8_to_fp32(a, a_fmt), fp8_to_fp32(b, b_fmt));
            running_sum = fp32_add_rne(running_sum, prod);
            if (fp32_is_nan(running_sum))
                running_sum = QNAN_BITS;
            if (last) begin
                pending_sums.push_back(running_sum);
                running_sum = 32'd0;
            end
        endfunction

        function void check_sum(logic [31:0] got);
            logic [31:0] want;
            if (pending_sums.size() == 0) begin
                $error("sum_bits: unexpected beat, actual %h", got);
                mismatches++;
                return;
            end
            want = pending_sums.pop_front();
            sums_checked++;
            if (got !== want) begin
                $error("sum_bits: expected %h, actual %h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           a_code;
    logic [7:0]           b_code;
    logic                 last_term;
    logic                 out_valid;
    logic                 out_ready;
    logic [31:0]          sum_bits;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;

    dot_sum_checker sums;
    logic           idle_on;
    logic           hold_request;
    int             pairs_sent;
    int             cycle_count = 0;
    int             cfg_writes;

    fp8_dot_product_accumulate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_code    (a_code),
        .b_code    (b_code),
        .last_term (last_term),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum_bits  (sum_bits),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check each beat, stall in random bursts
    initial
    begin : result_side
        int stall_left;
        int run_left;
        bit hold_taken;
        stall_left = 0;
        run_left = 0;
        hold_taken = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sums.check_sum(sum_bits);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && run_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end
            else begin
                if (run_left == 0)
                    run_left = $urandom_range(1, 30);
                run_left--;
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one pair, hold it until taken
    task automatic send_pair(logic [7:0] a, logic [7:0] b, logic last);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_code <= a;
        b_code <= b;
        last_term <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sums.note_pair(a, b, last);
        pairs_sent++;
    endtask

    // Drain outstanding sums and let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sums.pending_sums.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write both format registers plus an out-of-range index
    task automatic set_formats(logic fa, logic fb);
        logic [CFG_IDX_W-1:0] idx[3];
        logic                 val[3];
        idx[0] = REG_A_FMT;
        val[0] = fa;
        idx[1] = REG_B_FMT;
        val[1] = fb;
        idx[2] = CFG_IDX_W'($urandom_range(2, 3));
        val[2] = 1'($urandom);
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx[i] == REG_A_FMT)
                sums.a_fmt = val[i];
            else if (idx[i] == REG_B_FMT)
                sums.b_fmt = val[i];
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic fp8_is_special(logic [7:0] c, logic is_e5m2);
        if (is_e5m2)
            return c[6:2] == 5'h1f;
        return c[6:0] == 7'h7f;
    endfunction

    // Mostly finite codes; NaN and infinity show up now and then
    function automatic logic [7:0] pick_code(logic is_e5m2);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 19) != 0)
            while (fp8_is_special(c, is_e5m2))
                c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic random_dots(int count);
        int left;
        int len;
        left = count;
        while (left > 0) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len && left > 0; i++) begin
                left--;
                send_pair(pick_code(sums.a_fmt), pick_code(sums.b_fmt),
                          (i == len - 1) || left == 0);
            end
        end
    endtask

    initial
    begin : stimulus
        logic fa_list[6];
        logic fb_list[6];
        sums = new();
        sums.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        a_code = 8'd0;
        b_code = 8'd0;
        last_term = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_A_FMT;
        cfg_data = 1'b0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        pairs_sent = 0;
        cfg_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // E4M3 x E4M3 after reset: extremes, zeros, subnormals, NaN
        send_pair(8'h7e, 8'h7e, 1'b1);
        send_pair(8'hfe, 8'h7e, 1'b0);
        send_pair(8'h7e, 8'h7e, 1'b1);
        send_pair(8'h00, 8'h80, 1'b1);
        send_pair(8'h80, 8'h7e, 1'b0);
        send_pair(8'h80, 8'h00, 1'b1);
        send_pair(8'h01, 8'h01, 1'b0);
        send_pair(8'h07, 8'h87, 1'b1);
        send_pair(8'h7f, 8'h38, 1'b0);
        send_pair(8'h38, 8'h38, 1'b1);
        send_pair(8'hff, 8'h00, 1'b1);
        send_pair(8'h38, 8'h38, 1'b0);
        send_pair(8'h01, 8'h01, 1'b1);
        wait_idle();

        // E5M2 x E5M2: infinities, invalid products and sums, subnormals
        set_formats(1'b1, 1'b1);
        send_pair(8'h7c, 8'h3c, 1'b1);
        send_pair(8'h7c, 8'h00, 1'b1);
        send_pair(8'h7c, 8'h3c, 1'b0);
        send_pair(8'hfc, 8'h3c, 1'b1);
        send_pair(8'hfc, 8'h7c, 1'b0);
        send_pair(8'hfc, 8'hfc, 1'b1);
        send_pair(8'h7d, 8'h3c, 1'b1);
        send_pair(8'h7b, 8'h7b, 1'b0);
        send_pair(8'hfb, 8'h7b, 1'b1);
        send_pair(8'h03, 8'h83, 1'b1);
        send_pair(8'h01, 8'h01, 1'b0);
        send_pair(8'h3c, 8'h3c, 1'b1);
        wait_idle();

        fa_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        fb_list = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        for (int ph = 0; ph < 6; ph++) begin
            set_formats(fa_list[ph], fb_list[ph]);
            if (ph == 2) begin
                // Long receiver stall while pairs keep coming
                hold_request <= 1'b1;
            end
            if (ph == 5)
                idle_on = 1'b0;
            random_dots(ITEMS_PHASE);
            wait_idle();
        end
        in_valid <= 1'b0;
        repeat (10) @(posedge clk);

        $display("Sent %0d FP8 pairs over all four format pairings, %0d register writes,",
                 pairs_sent, cfg_writes);
        $display("checked %0d fp32 sums with NaN, infinity and subnormal codes mixed in.",
                 sums.sums_checked);
        if (sums.mismatches == 0 && sums.pending_sums.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/fpda_pkg.sv
rtl/fpda_mul.sv
rtl/fpda_add.sv
rtl/fp8_dot_product_accumulate.sv
rtl/fpda_checker.sv
sim/tb_top.sv
